>>> hdl/assert_macros.svh
// Assertion macros shared by the printer character-set mapper RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge; ignored while reset is high.
`define UPC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("upc assertion failed");

// Check on every rising clock edge, reset cycles included.
`define UPC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("upc assertion failed");

`endif

>>> hdl/upc_pkg.sv
// Package for the printer character-set mapper: widths and lookup tables.
// No dependencies; imported by upc_map and the core top level.
package upc_pkg;

   localparam int CodeWidth  = 32;
   localparam int CharWidth  = 8;
   localparam int CyrDepth   = 64;
   localparam int SymCount   = 34;

   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [CharWidth-1:0] char_type;

   // Fixed codes of the mapping rules
   localparam char_type AsciiLow     = 8'h20;
   localparam code_type AsciiHigh    = 32'h0000_007E;
   localparam char_type LatinLead    = 8'hC2;
   localparam char_type LatinLow     = 8'hA0;
   localparam char_type CyrPage      = 8'h04;
   localparam char_type CyrLow       = 8'h10;
   localparam char_type CyrHigh      = 8'h4F;
   localparam char_type CyrYoLowerIn = 8'h51;
   localparam char_type CyrYoUpperIn = 8'h01;
   localparam char_type CyrYoLower   = 8'd203;
   localparam char_type CyrYoUpper   = 8'd235;

   // Cyrillic letters U+0410..U+044F
   localparam char_type CYR_MAP [CyrDepth] = '{
       8'd65,  8'd98,  8'd66, 8'd132,  8'd68,  8'd69, 8'd215,  8'd51,
       8'd73, 8'd209,  8'd75, 8'd182,  8'd77,  8'd72,  8'd79, 8'd156,
       8'd80,  8'd67,  8'd84,  8'd89, 8'd163,  8'd88,  8'd85,  8'd52,
      8'd154, 8'd154, 8'd254, 8'd198, 8'd254, 8'd162, 8'd222, 8'd182,
       8'd97, 8'd146, 8'd223, 8'd132, 8'd113, 8'd101, 8'd215,  8'd51,
      8'd105, 8'd209, 8'd107, 8'd150,  8'd77,  8'd72, 8'd111, 8'd135,
      8'd112,  8'd99, 8'd116, 8'd121, 8'd149, 8'd120, 8'd117,  8'd52,
      8'd154, 8'd154, 8'd254, 8'd230, 8'd254, 8'd170, 8'd222, 8'd240
   };

   // Symbol sequences (packed UTF-8) and their printer codes
   localparam code_type SYM_KEY [SymCount] = '{
      32'hE288A0, 32'hC397,   32'hE28887, 32'hE2889A, 32'hE288AB, 32'hE28891,
      32'hE296B6, 32'hCF80,   32'hE1B4A8, 32'hE28882, 32'hE289A4, 32'hE289A5,
      32'hE289A0, 32'hC991,   32'hE28692, 32'hE28690, 32'hE28693, 32'hE28691,
      32'hC9A3,   32'hCEB4,   32'hCEB5,   32'hCEB7,   32'hCEB8,   32'hCEBB,
      32'hCF81,   32'hCF83,   32'hCF84,   32'hCF89,   32'hE28886, 32'hE2888F,
      32'hE284A6, 32'hE2888E, 32'hE2889E, 32'hC9B7
   };

   localparam char_type SYM_CODE [SymCount] = '{
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85,
      8'h86, 8'h87, 8'h87, 8'h88, 8'h89, 8'h8A,
      8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90,
      8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
      8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C,
      8'h9D, 8'h9E, 8'h9F, 8'h9F
   };

endpackage

>>> hdl/upc_map.sv
// Combinational character mapper: packed code in, printer byte out.
// Depends on upc_pkg for the Cyrillic and symbol tables.
module upc_map
   import upc_pkg::*;
(
   input  code_type code_value,
   input  char_type filler_code,
   output char_type printer_char
);

   char_type byte0;
   char_type byte1;
   logic     sym_hit;
   char_type sym_char;
   logic [5:0] cyr_index;

   assign byte0     = code_value[7:0];
   assign byte1     = code_value[15:8];
   assign cyr_index = 6'(byte0 - CyrLow);

   // Symbol lookup: keys are distinct, so at most one compare hits
   always_comb begin
      sym_hit  = 1'b0;
      sym_char = '0;
      for (int i = 0; i < SymCount; i++) begin
         if (code_value == SYM_KEY[i]) begin
            sym_hit  = 1'b1;
            sym_char = sym_char | SYM_CODE[i];
         end
      end
   end

   // Rules in priority order
   always_comb begin
      priority if (code_value >= code_type'(AsciiLow) && code_value <= AsciiHigh) begin
         printer_char = byte0;
      end else if (byte1 == LatinLead && byte0 >= LatinLow) begin
         printer_char = byte0;
      end else if (byte1 == CyrPage && byte0 >= CyrLow && byte0 <= CyrHigh) begin
         printer_char = CYR_MAP[cyr_index];
      end else if (byte1 == CyrPage && byte0 == CyrYoLowerIn) begin
         printer_char = CyrYoLower;
      end else if (byte1 == CyrPage && byte0 == CyrYoUpperIn) begin
         printer_char = CyrYoUpper;
      end else if (sym_hit) begin
         printer_char = sym_char;
      end else begin
         printer_char = filler_code;
      end
   end

endmodule

>>> hdl/unicode_to_printer_charset_core.sv
// Channel   Direction  Handshake          Payload
// req_      in         valid / stall      code_value (32 bits)
// rsp_      out        valid / stall      printer_char (8 bits)
// csr_      in         valid / ready      filler_code (8 bits)
//
// One request per cycle sustained while rsp_stall is low; a result is offered once its
// request has passed the input register, mapping logic and result register.
// Reset is synchronous and clears both valid bits; filler_code resets to 0.
// A stalled result holds in the result register while one more request waits
// in the input register; req_stall rises only when both are full.
// Top level of the printer character-set mapper; uses upc_pkg, upc_map and
// assert_macros.svh.
`include "assert_macros.svh"

module unicode_to_printer_charset_core
   import upc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  code_type req_code_value,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output char_type rsp_printer_char,
   input  logic     csr_valid,
   output logic     csr_ready,
   input  char_type csr_filler_code
);

   logic     in_valid_ff, in_valid_in;
   code_type in_code_ff, in_code_in;
   logic     out_valid_ff, out_valid_in;
   char_type out_char_ff, out_char_in;
   char_type filler_ff, filler_in;
   char_type mapped_char;
   logic     out_advance;
   logic     in_advance;
   logic     req_take;

   // Pipeline flow control
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_stall   = !in_advance;
   assign req_take    = req_valid && in_advance;
   assign csr_ready   = 1'b1;

   upc_map u_map (
      .code_value   (in_code_ff),
      .filler_code  (filler_ff),
      .printer_char (mapped_char)
   );

   // Next values of the stage registers
   always_comb begin
      in_valid_in  = in_advance ? req_valid : in_valid_ff;
      in_code_in   = req_take ? req_code_value : in_code_ff;
      out_valid_in = out_advance ? in_valid_ff : out_valid_ff;
      out_char_in  = (out_advance && in_valid_ff) ? mapped_char : out_char_ff;
      filler_in    = (csr_valid && csr_ready) ? csr_filler_code : filler_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         filler_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         filler_ff    <= filler_in;
      end
   end

   always_ff @(posedge clock) begin
      in_code_ff  <= in_code_in;
      out_char_ff <= out_char_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_printer_char = out_char_ff;

   // Checks
   `UPC_ASSERT_ALWAYS(a_reset_clears, reset |=> !in_valid_ff && !out_valid_ff)
   `UPC_ASSERT(a_stall_only_full, req_stall |-> in_valid_ff && out_valid_ff)
   `UPC_ASSERT(a_take_lands, req_take |=> in_valid_ff && in_code_ff == $past(req_code_value))
   `UPC_ASSERT(a_held_request, in_valid_ff && !out_advance |=> in_valid_ff && $stable(in_code_ff))

endmodule
